// ----- rtl/iad_pkg.sv -----
// Shared types and codes for the integer ALU with divide and square root.
package iad_pkg;

  // Operation codes
  localparam logic [2:0] OP_ADD  = 3'd1;
  localparam logic [2:0] OP_SUB  = 3'd2;
  localparam logic [2:0] OP_MUL  = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_SQR  = 3'd5;
  localparam logic [2:0] OP_ROOT = 3'd6;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIV_ZERO = 2'd1;
  localparam logic [1:0] ST_NEG_ROOT = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_ITER,
    S_FIX,
    S_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic prep;  // set up operands, or finish the non-iterative ops
    logic iter;  // one step of multiply, square, divide or root
    logic fix;   // sign fix and result select
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic iterate;  // op needs the iterative unit
    logic root;     // op is square root (half the step count)
  } dp_stat_t;

endpackage

// ----- rtl/iad_datapath.sv -----
// Datapath: operand registers, shared subtractor and shift-add / restoring units.
module iad_datapath #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                   clk_i,
  input  iad_pkg::dp_cmd_t       cmd_i,
  output iad_pkg::dp_stat_t      stat_o,
  input  logic [2:0]             op_i,
  input  logic [DATA_WIDTH-1:0]  operand_a_i,
  input  logic [DATA_WIDTH-1:0]  operand_b_i,
  output logic [DATA_WIDTH-1:0]  result_o,
  output logic [1:0]             status_o
);

  localparam int W  = DATA_WIDTH;
  localparam int SH = DATA_WIDTH % 2;  // align radicand to an even bit count

  logic [2:0]   op_q;
  logic [W-1:0] a_q, b_q, n_q;
  logic [W-1:0] x_q, y_q, q_q, res_q;
  logic [W+1:0] rem_q;
  logic         neg_q;
  logic [1:0]   st_q;

  logic         is_root;
  logic [W+1:0] sub_a, sub_b;
  logic [W+2:0] diff;
  logic         fits;
  logic [W-1:0] n_mag, b_mag;
  logic [W-1:0] prep_res;
  logic [1:0]   prep_st;
  logic         prep_neg;

  assign is_root = (op_q == iad_pkg::OP_ROOT);

  // Magnitudes for the divider
  assign n_mag = n_q[W-1] ? (~n_q + 1'b1) : n_q;
  assign b_mag = b_q[W-1] ? (~b_q + 1'b1) : b_q;

  // Shared trial subtract: divide brings one bit, root brings a bit pair
  assign sub_a = is_root ? {rem_q[W-1:0], x_q[W-1:W-2]} : {rem_q[W:0], x_q[W-1]};
  assign sub_b = is_root ? {q_q, 2'b01} : {2'b00, y_q};
  assign diff  = {1'b0, sub_a} - {1'b0, sub_b};
  assign fits  = ~diff[W+2];

  // Status toward the controller
  always_comb begin
    stat_o.root    = is_root;
    stat_o.iterate = 1'b0;
    unique case (op_q) inside
      iad_pkg::OP_MUL, iad_pkg::OP_SQR: stat_o.iterate = 1'b1;
      iad_pkg::OP_DIV:                  stat_o.iterate = (b_q != '0);
      iad_pkg::OP_ROOT:                 stat_o.iterate = ~a_q[W-1];
      default:                          stat_o.iterate = 1'b0;
    endcase
  end

  // Setup step: add and subtract results, error status and quotient sign
  always_comb begin
    prep_res = '0;
    prep_st  = iad_pkg::ST_OK;
    prep_neg = 1'b0;
    unique case (op_q)
      iad_pkg::OP_ADD: prep_res = a_q + b_q;
      iad_pkg::OP_SUB: prep_res = a_q - b_q;
      iad_pkg::OP_DIV: begin
        if (b_q == '0) begin
          prep_st = iad_pkg::ST_DIV_ZERO;
        end else begin
          prep_neg = n_q[W-1] ^ b_q[W-1];
        end
      end
      iad_pkg::OP_ROOT: begin
        if (a_q[W-1]) begin
          prep_st = iad_pkg::ST_NEG_ROOT;
        end
      end
      default: prep_res = '0;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      a_q  <= operand_a_i;
      b_q  <= operand_b_i;
      n_q  <= (operand_a_i << 3) + (operand_a_i << 1);  // a * 10, wrapped
    end

    if (cmd_i.prep) begin
      rem_q <= '0;
      q_q   <= '0;
      res_q <= prep_res;
      st_q  <= prep_st;
      neg_q <= prep_neg;
      unique case (op_q)
        iad_pkg::OP_MUL: begin
          x_q <= b_q;
          y_q <= a_q;
        end
        iad_pkg::OP_SQR: begin
          x_q <= a_q;
          y_q <= a_q;
        end
        iad_pkg::OP_DIV: begin
          x_q <= n_mag;
          y_q <= b_mag;
        end
        iad_pkg::OP_ROOT: x_q <= a_q << SH;
        default: x_q <= x_q;
      endcase
    end

    // One iteration step
    if (cmd_i.iter) begin
      unique case (op_q) inside
        iad_pkg::OP_MUL, iad_pkg::OP_SQR: begin
          if (x_q[0]) begin
            q_q <= q_q + y_q;
          end
          y_q <= y_q << 1;
          x_q <= x_q >> 1;
        end
        iad_pkg::OP_DIV: begin
          rem_q <= fits ? diff[W+1:0] : sub_a;
          q_q   <= {q_q[W-2:0], fits};
          x_q   <= x_q << 1;
        end
        iad_pkg::OP_ROOT: begin
          rem_q <= fits ? diff[W+1:0] : sub_a;
          q_q   <= {q_q[W-2:0], fits};
          x_q   <= x_q << 2;
        end
        default: q_q <= q_q;
      endcase
    end

    // Quotient sign and result select
    if (cmd_i.fix) begin
      res_q <= ((op_q == iad_pkg::OP_DIV) && neg_q) ? (~q_q + 1'b1) : q_q;
    end
  end

  assign result_o = res_q;
  assign status_o = st_q;

endmodule

// ----- rtl/iad_ctrl.sv -----
// Controller: sequences load, setup, iteration steps, sign fix and the result strobe.
module iad_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  output logic               done_o,
  output iad_pkg::dp_cmd_t   cmd_o,
  input  iad_pkg::dp_stat_t  stat_i
);

  localparam int CW = $clog2(DATA_WIDTH + 1);

  iad_pkg::state_e state_q, state_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  // State and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iad_pkg::S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      iad_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = iad_pkg::S_PREP;
        end
      end
      iad_pkg::S_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = stat_i.root ? CW'(DATA_WIDTH / 2) : CW'(DATA_WIDTH);
        state_d    = stat_i.iterate ? iad_pkg::S_ITER : iad_pkg::S_OUT;
      end
      iad_pkg::S_ITER: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          state_d = iad_pkg::S_FIX;
        end
      end
      iad_pkg::S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = iad_pkg::S_OUT;
      end
      iad_pkg::S_OUT: begin
        done_o  = 1'b1;
        state_d = iad_pkg::S_IDLE;
      end
      default: state_d = iad_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- rtl/integer_alu_div_sqrt_top.sv -----
// Top level of the integer ALU with fixed-point divide and square root.
//
//  channel  | handshake             | word
//  ---------+-----------------------+----------------------------------
//  command  | start, busy           | op_i, operand_a_i, operand_b_i
//  result   | done_o (1-cycle pulse)| result_o, status_o
//
// A word is taken when start is high and busy is low. Add, subtract, unused
// opcodes and the error cases go from setup straight to done_o; multiply,
// square and divide run DATA_WIDTH steps, root DATA_WIDTH/2 steps, in the
// one-bit-per-cycle shift-add and restoring loop, then a sign fix. busy stays
// high until the done_o cycle ends; the next word can be taken in the cycle
// after done_o. Reset is asynchronous, active low.
module integer_alu_div_sqrt_top #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   op_i,
  input  logic signed [DATA_WIDTH-1:0] operand_a_i,
  input  logic signed [DATA_WIDTH-1:0] operand_b_i,
  output logic                         done_o,
  output logic signed [DATA_WIDTH-1:0] result_o,
  output logic [1:0]                   status_o
);

  iad_pkg::dp_cmd_t  cmd;
  iad_pkg::dp_stat_t stat;
  logic [DATA_WIDTH-1:0] res;

  iad_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  iad_datapath #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .operand_a_i (operand_a_i),
    .operand_b_i (operand_b_i),
    .result_o    (res),
    .status_o    (status_o)
  );

  assign result_o = res;

endmodule
